@@ hw/rtl/ttw_pkg.sv @@
package ttw_pkg;

	localparam int COLUMNS_DEFAULT = 80;
	localparam int ROWS_DEFAULT    = 25;

	localparam logic [7:0]  NEWLINE_CHAR       = 8'd10;
	localparam logic [7:0]  TEXT_COLOR_RESET   = 8'h07;
	localparam logic [15:0] BLANK_CELL_RESET   = 16'h0000;

	// register index, taken from paddr[2]
	localparam logic REG_TEXT_COLOR = 1'b0;
	localparam logic REG_BLANK_CELL = 1'b1;

	typedef enum logic [2:0] {
		OP_PUT_CHAR = 3'd0,
		OP_PUT_RAW  = 3'd1,
		OP_SET_POS  = 3'd2,
		OP_CLEAR    = 3'd3,
		OP_READ     = 3'd4
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_SCROLL,
		ST_CLEAR,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] char_code;
		logic [7:0] attribute;
		logic       use_default_color;
		logic [4:0] target_row;
		logic [6:0] target_col;
	} item_t;

	typedef struct packed {
		logic [10:0] cursor_position;
		logic [4:0]  cursor_row;
		logic [6:0]  cursor_col;
		logic [15:0] cell_data;
		logic        scrolled;
	} result_t;

endpackage

@@ hw/rtl/ttw_ram.sv @@
module ttw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 2000,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ hw/rtl/ttw_ctrl.sv @@
module ttw_ctrl #(
	parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = ttw_pkg::ROWS_DEFAULT,
	localparam int CELL_COUNT = COLUMNS * ROWS,
	localparam int POS_W  = $clog2(CELL_COUNT),
	localparam int ROW_W  = $clog2(ROWS),
	localparam int COL_W  = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
	localparam int WALK_W = $clog2(CELL_COUNT + COLUMNS)
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                accept,
	input  ttw_pkg::item_t      item,
	input  logic [7:0]          text_color,
	input  logic [15:0]         blank_cell,
	input  logic                out_free,
	output logic                busy,
	output logic                result_load,
	output ttw_pkg::result_t    result,
	output logic                ram_we,
	output logic [POS_W-1:0]    ram_waddr,
	output logic [15:0]         ram_wdata,
	output logic                ram_re,
	output logic [POS_W-1:0]    ram_raddr,
	input  logic [15:0]         ram_rdata
);

	ttw_pkg::state_t state_q, state_d;
	ttw_pkg::item_t  item_q;

	logic [ROW_W-1:0]  row_q, row_d;
	logic [COL_W-1:0]  col_q, col_d;
	logic [POS_W-1:0]  pos_q, pos_d;
	logic [WALK_W-1:0] walk_q, walk_d;
	logic              scrolled_q, scrolled_d;
	logic              rd_hit_q, rd_hit_d;
	logic              pend_q, pend_d;
	logic              wb_blank_q, wb_blank_d;
	logic [POS_W-1:0]  wb_addr_q, wb_addr_d;

	logic [7:0]        attr;
	logic [15:0]       item_cell;
	logic              tgt_hit;
	logic [POS_W-1:0]  tgt_pos;
	logic              col_last;
	logic              row_last;
	logic              is_put;
	logic              is_newline;

	assign attr      = item_q.use_default_color ? text_color : item_q.attribute;
	assign item_cell = {attr, item_q.char_code};
	assign tgt_hit   = (6'(item_q.target_row) < 6'(ROWS)) &&
		(8'(item_q.target_col) < 8'(COLUMNS));
	assign tgt_pos   = POS_W'(item_q.target_row) * POS_W'(COLUMNS) +
		POS_W'(item_q.target_col);
	assign col_last  = (col_q == COL_W'(COLUMNS - 1));
	assign row_last  = (row_q == ROW_W'(ROWS - 1));
	assign is_newline = (item_q.operation == ttw_pkg::OP_PUT_CHAR) &&
		(item_q.char_code == ttw_pkg::NEWLINE_CHAR);
	assign is_put = ((item_q.operation == ttw_pkg::OP_PUT_CHAR) && !is_newline) ||
		(item_q.operation == ttw_pkg::OP_PUT_RAW);

	assign busy = (state_q != ttw_pkg::ST_IDLE);

	always_comb begin
		result.cursor_position = 11'(pos_q);
		result.cursor_row      = 5'(row_q);
		result.cursor_col      = 7'(col_q);
		result.cell_data       = rd_hit_q ? ram_rdata : 16'h0000;
		result.scrolled        = scrolled_q;
	end

	always_comb begin
		state_d     = state_q;
		row_d       = row_q;
		col_d       = col_q;
		pos_d       = pos_q;
		walk_d      = walk_q;
		scrolled_d  = scrolled_q;
		rd_hit_d    = rd_hit_q;
		pend_d      = 1'b0;
		wb_blank_d  = wb_blank_q;
		wb_addr_d   = wb_addr_q;
		result_load = 1'b0;
		ram_re      = 1'b0;
		ram_raddr   = tgt_pos;
		ram_we      = 1'b0;
		ram_waddr   = pos_q;
		ram_wdata   = item_cell;

		// scroll copy lands in the cycle after its read
		if (pend_q) begin
			ram_we    = 1'b1;
			ram_waddr = wb_addr_q;
			ram_wdata = wb_blank_q ? blank_cell : ram_rdata;
		end

		unique case (state_q)
			ttw_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = ttw_pkg::ST_EXEC;
				end
			end
			ttw_pkg::ST_EXEC: begin
				scrolled_d = 1'b0;
				rd_hit_d   = 1'b0;
				state_d    = ttw_pkg::ST_DONE;
				if (is_put || is_newline) begin
					if (is_put) begin
						ram_we = 1'b1;
					end
					if (is_newline || col_last) begin
						col_d = '0;
						if (row_last) begin
							row_d      = ROW_W'(ROWS - 1);
							pos_d      = POS_W'(COLUMNS * (ROWS - 1));
							walk_d     = WALK_W'(COLUMNS);
							scrolled_d = 1'b1;
							state_d    = ttw_pkg::ST_SCROLL;
						end else begin
							row_d = row_q + ROW_W'(1);
							pos_d = is_newline ?
								pos_q - POS_W'(col_q) + POS_W'(COLUMNS) :
								pos_q + POS_W'(1);
						end
					end else begin
						col_d = col_q + COL_W'(1);
						pos_d = pos_q + POS_W'(1);
					end
				end else begin
					case (item_q.operation)
						ttw_pkg::OP_SET_POS: begin
							if (tgt_hit) begin
								row_d = ROW_W'(item_q.target_row);
								col_d = COL_W'(item_q.target_col);
								pos_d = tgt_pos;
							end
						end
						ttw_pkg::OP_CLEAR: begin
							row_d   = '0;
							col_d   = '0;
							pos_d   = '0;
							walk_d  = '0;
							state_d = ttw_pkg::ST_CLEAR;
						end
						ttw_pkg::OP_READ: begin
							ram_re   = tgt_hit;
							rd_hit_d = tgt_hit;
						end
						default: begin
						end
					endcase
				end
			end
			ttw_pkg::ST_SCROLL: begin
				// walk reads row r+1 and writes row r; past the end it fills blank
				pend_d     = 1'b1;
				wb_addr_d  = POS_W'(walk_q - WALK_W'(COLUMNS));
				wb_blank_d = (walk_q >= WALK_W'(CELL_COUNT));
				ram_re     = (walk_q < WALK_W'(CELL_COUNT));
				ram_raddr  = POS_W'(walk_q);
				walk_d     = walk_q + WALK_W'(1);
				if (walk_q == WALK_W'(CELL_COUNT + COLUMNS - 1)) begin
					state_d = ttw_pkg::ST_DONE;
				end
			end
			ttw_pkg::ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = POS_W'(walk_q);
				ram_wdata = blank_cell;
				walk_d    = walk_q + WALK_W'(1);
				if (walk_q == WALK_W'(CELL_COUNT - 1)) begin
					state_d = ttw_pkg::ST_DONE;
				end
			end
			ttw_pkg::ST_DONE: begin
				if (out_free) begin
					result_load = 1'b1;
					state_d     = ttw_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ttw_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ttw_pkg::ST_IDLE;
			row_q      <= '0;
			col_q      <= '0;
			pos_q      <= '0;
			walk_q     <= '0;
			scrolled_q <= 1'b0;
			rd_hit_q   <= 1'b0;
			pend_q     <= 1'b0;
		end else begin
			state_q    <= state_d;
			row_q      <= row_d;
			col_q      <= col_d;
			pos_q      <= pos_d;
			walk_q     <= walk_d;
			scrolled_q <= scrolled_d;
			rd_hit_q   <= rd_hit_d;
			pend_q     <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= item;
		end
		wb_blank_q <= wb_blank_d;
		wb_addr_q  <= wb_addr_d;
	end

endmodule

@@ hw/rtl/text_terminal_writer_core.sv @@
// Channel  | Direction | Handshake            | Payload
// ---------+-----------+----------------------+---------------------------------------
// in       | to core   | in_valid / in_stall  | operation, char_code, attribute,
//          |           |                      | use_default_color, target_row, target_col
// out      | from core | out_valid / out_stall| cursor_position, cursor_row, cursor_col,
//          |           |                      | cell_data, scrolled
// cfg      | to core   | APB psel/penable     | text_color (0x0), blank_cell (0x4)
//
// Each item passes through accept, execute and result load when it writes at most one cell.
// A clear and a scroll each walk all ROWS*COLUMNS cells: both are paced by
// the single write port of the cell memory, walked one cell per cycle by the sequencer.
// Reset puts the cursor home and the config registers to their defaults; the cell memory
// is not cleared, so software issues a clear before reading cells.
// The input is stalled while an item is in work; a result waiting on out_stall does not
// block the next transfer in, only the load of that item's own result.
module text_terminal_writer_core #(
	parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
	parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  operation,
	input  logic [7:0]  char_code,
	input  logic [7:0]  attribute,
	input  logic        use_default_color,
	input  logic [4:0]  target_row,
	input  logic [6:0]  target_col,

	output logic        out_valid,
	input  logic        out_stall,
	output logic [10:0] cursor_position,
	output logic [4:0]  cursor_row,
	output logic [6:0]  cursor_col,
	output logic [15:0] cell_data,
	output logic        scrolled,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int CELL_COUNT = COLUMNS * ROWS;
	localparam int POS_W      = $clog2(CELL_COUNT);

	// config registers
	logic [7:0]  text_color_q;
	logic [15:0] blank_cell_q;
	logic        cfg_wr;

	// output register
	logic             out_valid_q;
	ttw_pkg::result_t result_q;

	ttw_pkg::item_t   item;
	ttw_pkg::result_t result;
	logic             accept;
	logic             busy;
	logic             result_load;
	logic             out_free;

	logic             ram_we;
	logic [POS_W-1:0] ram_waddr;
	logic [15:0]      ram_wdata;
	logic             ram_re;
	logic [POS_W-1:0] ram_raddr;
	logic [15:0]      ram_rdata;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_comb begin
		unique case (paddr[2])
			ttw_pkg::REG_TEXT_COLOR: prdata = {24'h000000, text_color_q};
			ttw_pkg::REG_BLANK_CELL: prdata = {16'h0000, blank_cell_q};
			default:                 prdata = 32'h00000000;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= ttw_pkg::TEXT_COLOR_RESET;
			blank_cell_q <= ttw_pkg::BLANK_CELL_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[2])
				ttw_pkg::REG_TEXT_COLOR: text_color_q <= pwdata[7:0];
				ttw_pkg::REG_BLANK_CELL: blank_cell_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// input transfer
	assign in_stall = busy;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		item.operation         = operation;
		item.char_code         = char_code;
		item.attribute         = attribute;
		item.use_default_color = use_default_color;
		item.target_row        = target_row;
		item.target_col        = target_col;
	end

	// output slot is free when empty or when its transfer completes this cycle
	assign out_free = !out_valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_load) begin
			result_q <= result;
		end
	end

	assign out_valid       = out_valid_q;
	assign cursor_position = result_q.cursor_position;
	assign cursor_row      = result_q.cursor_row;
	assign cursor_col      = result_q.cursor_col;
	assign cell_data       = result_q.cell_data;
	assign scrolled        = result_q.scrolled;

	ttw_ctrl #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.item        (item),
		.text_color  (text_color_q),
		.blank_cell  (blank_cell_q),
		.out_free    (out_free),
		.busy        (busy),
		.result_load (result_load),
		.result      (result),
		.ram_we      (ram_we),
		.ram_waddr   (ram_waddr),
		.ram_wdata   (ram_wdata),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata)
	);

	ttw_ram #(
		.WIDTH (16),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
	import ttw_pkg::*;

	localparam int SCREEN_COLS = COLUMNS_DEFAULT;
	localparam int SCREEN_ROWS = ROWS_DEFAULT;
	localparam int SCREEN_CELLS = SCREEN_COLS * SCREEN_ROWS;

	// operations 5..7 are unused codes; the core must leave everything alone
	localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
	localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

	// byte addresses on the config port
	localparam logic [2:0] ADDR_TEXT_COLOR = {REG_TEXT_COLOR, 2'b00};
	localparam logic [2:0] ADDR_BLANK_CELL = {REG_BLANK_CELL, 2'b00};

	// a clear or a scroll walks all cells once; the limit covers every item
	// doing a full walk plus stalls, several times over
	localparam int CYCLE_LIMIT = 6_000_000;

	logic        clk = 1'b0;
	logic        arst_n;

	logic        in_valid;
	logic        in_stall;
	logic [2:0]  operation;
	logic [7:0]  char_code;
	logic [7:0]  attribute;
	logic        use_default_color;
	logic [4:0]  target_row;
	logic [6:0]  target_col;

	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [10:0] cursor_position;
	logic [4:0]  cursor_row;
	logic [6:0]  cursor_col;
	logic [15:0] cell_data;
	logic        scrolled;

	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	// shadow of the screen: cell contents, which cells hold defined data,
	// the write position and the two config registers
	logic [15:0] screen_q [0:SCREEN_CELLS-1];
	bit          known_q [0:SCREEN_CELLS-1];
	int unsigned cursor_q;
	logic [7:0]  color_q;
	logic [15:0] blank_q;

	result_t     awaited_status [$];
	int          mismatch_count = 0;
	int          cycle_count = 0;
	bit          steady;   // set: neither side idles nor stalls

	text_terminal_writer_core #(
		.COLUMNS(SCREEN_COLS),
		.ROWS(SCREEN_ROWS)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.operation(operation),
		.char_code(char_code),
		.attribute(attribute),
		.use_default_color(use_default_color),
		.target_row(target_row),
		.target_col(target_col),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.cursor_position(cursor_position),
		.cursor_row(cursor_row),
		.cursor_col(cursor_col),
		.cell_data(cell_data),
		.scrolled(scrolled),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	always #4 clk = ~clk;

	// run guard
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// receiver backpressure at random, about 8 percent of the time, only while not steady
	always @(posedge clk) begin
		out_stall <= !steady && ($urandom_range(99) < 8);
	end

	// ---------------------------------------------------------------------
	// Screen predictor
	// ---------------------------------------------------------------------

	// shift up one row, blank the bottom row, cursor to start of last row
	task automatic scroll_screen();
		for (int i = 0; i < SCREEN_COLS * (SCREEN_ROWS - 1); i++) begin
			screen_q[i] = screen_q[i + SCREEN_COLS];
			known_q[i]  = known_q[i + SCREEN_COLS];
		end
		for (int i = SCREEN_COLS * (SCREEN_ROWS - 1); i < SCREEN_CELLS; i++) begin
			screen_q[i] = blank_q;
			known_q[i]  = 1'b1;
		end
		cursor_q = SCREEN_COLS * (SCREEN_ROWS - 1);
	endtask

	task automatic store_cell(input logic [15:0] entry, output bit wrapped);
		screen_q[cursor_q] = entry;
		known_q[cursor_q]  = 1'b1;
		cursor_q++;
		wrapped = 1'b0;
		if (cursor_q >= SCREEN_CELLS) begin
			scroll_screen();
			wrapped = 1'b1;
		end
	endtask

	// applies one command to the shadow screen and gives the status it reports
	task automatic predict_terminal(input item_t it, output result_t status);
		logic [7:0]  attr_v;
		logic [15:0] data_v;
		bit          wrapped;
		bit          on_screen;
		attr_v    = it.use_default_color ? color_q : it.attribute;
		data_v    = '0;
		wrapped   = 1'b0;
		on_screen = (it.target_row < SCREEN_ROWS) && (it.target_col < SCREEN_COLS);
		case (it.operation)
			OP_PUT_CHAR: begin
				if (it.char_code == NEWLINE_CHAR) begin
					// newline writes nothing, jumps to column 0 of the next row
					cursor_q += SCREEN_COLS - cursor_q % SCREEN_COLS;
					if (cursor_q >= SCREEN_CELLS) begin
						scroll_screen();
						wrapped = 1'b1;
					end
				end else begin
					store_cell({attr_v, it.char_code}, wrapped);
				end
			end
			// raw cell: code 10 is just another character here
			OP_PUT_RAW: store_cell({attr_v, it.char_code}, wrapped);
			OP_SET_POS: begin
				// off-screen targets are dropped
				if (on_screen)
					cursor_q = it.target_row * SCREEN_COLS + it.target_col;
			end
			OP_CLEAR: begin
				for (int i = 0; i < SCREEN_CELLS; i++) begin
					screen_q[i] = blank_q;
					known_q[i]  = 1'b1;
				end
				cursor_q = 0;
			end
			OP_READ: begin
				// off-screen read gives zero
				if (on_screen)
					data_v = screen_q[it.target_row * SCREEN_COLS + it.target_col];
			end
			default: ;
		endcase
		status.cursor_position = 11'(cursor_q);
		status.cursor_row      = 5'(cursor_q / SCREEN_COLS);
		status.cursor_col      = 7'(cursor_q % SCREEN_COLS);
		status.cell_data       = data_v;
		status.scrolled        = wrapped;
	endtask

	// ---------------------------------------------------------------------
	// Result checker: each output transfer against the oldest prediction
	// ---------------------------------------------------------------------

	task automatic compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
			mismatch_count++;
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (awaited_status.size() == 0) begin
				$display("%0t: unexpected result, expected none, actual pos %0d data %0h",
					$time, cursor_position, cell_data);
				mismatch_count++;
			end else begin
				want = awaited_status.pop_front();
				compare_field("cursor_position", 32'(want.cursor_position),
					32'(cursor_position));
				compare_field("cursor_row", 32'(want.cursor_row), 32'(cursor_row));
				compare_field("cursor_col", 32'(want.cursor_col), 32'(cursor_col));
				compare_field("cell_data", 32'(want.cell_data), 32'(cell_data));
				compare_field("scrolled", 32'(want.scrolled), 32'(scrolled));
			end
		end
	end

	// ---------------------------------------------------------------------
	// Stimulus helpers
	// ---------------------------------------------------------------------

	function automatic item_t make_item(input logic [2:0] op, input logic [7:0] ch,
			input logic [7:0] attr, input logic use_def,
			input logic [4:0] row, input logic [6:0] col);
		item_t it;
		it.operation         = op;
		it.char_code         = ch;
		it.attribute         = attr;
		it.use_default_color = use_def;
		it.target_row        = row;
		it.target_col        = col;
		return it;
	endfunction

	// one input transfer; valid stays up on return so back-to-back commands
	// follow without a gap
	task automatic issue_command(input item_t it);
		result_t status;
		while (!steady && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		operation         <= it.operation;
		char_code         <= it.char_code;
		attribute         <= it.attribute;
		use_default_color <= it.use_default_color;
		target_row        <= it.target_row;
		target_col        <= it.target_col;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_terminal(it, status);
		awaited_status.push_back(status);
	endtask

	// drop valid, wait out all results, then leave a margin
	task automatic settle_idle();
		in_valid <= 1'b0;
		while (awaited_status.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// setup cycle, access cycle, then the port is released
	task automatic program_register(input logic [2:0] addr, input logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (addr == ADDR_TEXT_COLOR)
			color_q = value[7:0];
		else
			blank_q = value[15:0];
		@(posedge clk);
	endtask

	// ---------------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------------

	// reset defaults: color 7 and cursor home; cells written before any clear
	task automatic test_reset_defaults();
		issue_command(make_item(OP_PUT_CHAR, 8'h41, 8'h5A, 1'b1, 5'd0, 7'd0));
		issue_command(make_item(OP_PUT_RAW, NEWLINE_CHAR, 8'hFF, 1'b0, 5'd3, 7'd9));
		issue_command(make_item(OP_READ, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0));
		issue_command(make_item(OP_READ, 8'hFF, 8'hFF, 1'b1, 5'd0, 7'd1));
		issue_command(make_item(OP_READ, 8'h00, 8'h00, 1'b0, 5'd31, 7'd127));
		issue_command(make_item(OP_SET_POS, 8'h00, 8'h00, 1'b0, 5'(SCREEN_ROWS), 7'd0));
		issue_command(make_item(OP_SET_POS, 8'h00, 8'h00, 1'b0, 5'd0, 7'(SCREEN_COLS)));
		issue_command(make_item(OP_SET_POS, 8'h00, 8'h00, 1'b0,
			5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1)));
		issue_command(make_item(OP_UNUSED_LAST, 8'hFF, 8'hFF, 1'b1, 5'd31, 7'd127));
		issue_command(make_item(OP_CLEAR, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0));
	endtask

	// all-ones registers, clear fill, default color, put on the last cell
	task automatic test_color_and_blank_extremes();
		settle_idle();
		program_register(ADDR_TEXT_COLOR, 32'hFFFF_FFFF);
		program_register(ADDR_BLANK_CELL, 32'hFFFF_FFFF);
		issue_command(make_item(OP_CLEAR, 8'hFF, 8'hFF, 1'b1, 5'd31, 7'd127));
		issue_command(make_item(OP_READ, 8'h00, 8'h00, 1'b0,
			5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1)));
		issue_command(make_item(OP_PUT_CHAR, 8'h00, 8'h00, 1'b1, 5'd0, 7'd0));
		issue_command(make_item(OP_SET_POS, 8'h00, 8'h00, 1'b0,
			5'(SCREEN_ROWS - 1), 7'(SCREEN_COLS - 1)));
		// writing the last cell scrolls: it lands at the end of row 23
		issue_command(make_item(OP_PUT_CHAR, 8'hFF, 8'h00, 1'b0, 5'd0, 7'd0));
		issue_command(make_item(OP_READ, 8'h00, 8'h00, 1'b0,
			5'(SCREEN_ROWS - 2), 7'(SCREEN_COLS - 1)));
		issue_command(make_item(OP_READ, 8'h00, 8'h00, 1'b0, 5'(SCREEN_ROWS - 1), 7'd0));
		settle_idle();
		program_register(ADDR_TEXT_COLOR, 32'h0000_0000);
		program_register(ADDR_BLANK_CELL, 32'h0000_0000);
	endtask

	// newline on the bottom row scrolls; newline at column 0 still advances a row
	task automatic test_newline_and_scroll();
		issue_command(make_item(OP_SET_POS, 8'h00, 8'h00, 1'b0, 5'(SCREEN_ROWS - 1), 7'd5));
		issue_command(make_item(OP_PUT_CHAR, NEWLINE_CHAR, 8'h12, 1'b0, 5'd0, 7'd0));
		issue_command(make_item(OP_PUT_CHAR, NEWLINE_CHAR, 8'h34, 1'b1, 5'd0, 7'd0));
		issue_command(make_item(OP_SET_POS, 8'h00, 8'h00, 1'b0, 5'd0, 7'd0));
		issue_command(make_item(OP_PUT_CHAR, NEWLINE_CHAR, 8'h00, 1'b0, 5'd0, 7'd0));
		issue_command(make_item(OP_PUT_RAW, NEWLINE_CHAR, 8'h77, 1'b1, 5'd0, 7'd0));
		issue_command(make_item(OP_READ, 8'h00, 8'h00, 1'b0, 5'd1, 7'd0));
	endtask

	// mixed traffic under one register setting; set-position is biased to
	// the bottom rows so that puts and newlines run into scrolls often
	task automatic test_random_traffic(input logic [7:0] color, input logic [15:0] blank,
			input int count, input bit burst);
		item_t it;
		int    pick;
		int    spot;
		settle_idle();
		program_register(ADDR_TEXT_COLOR, {16'($urandom_range(16'hFFFF)), 8'h00, color});
		program_register(ADDR_BLANK_CELL, {16'($urandom_range(16'hFFFF)), blank});
		steady = burst;
		for (int n = 0; n < count; n++) begin
			it = make_item(OP_PUT_CHAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
				1'($urandom_range(1)), 5'($urandom_range(31)), 7'($urandom_range(127)));
			pick = $urandom_range(99);
			if (pick < 34) begin
				if ($urandom_range(5) == 0)
					it.char_code = NEWLINE_CHAR;
			end else if (pick < 52) begin
				it.operation = OP_PUT_RAW;
				if ($urandom_range(7) == 0)
					it.char_code = NEWLINE_CHAR;
			end else if (pick < 66) begin
				it.operation = OP_SET_POS;
				spot = $urandom_range(7);
				if (spot < 4) begin
					it.target_row = 5'($urandom_range(SCREEN_ROWS - 1, SCREEN_ROWS - 2));
					it.target_col = 7'($urandom_range(SCREEN_COLS - 1, SCREEN_COLS - 20));
				end else if (spot < 7) begin
					it.target_row = 5'($urandom_range(SCREEN_ROWS - 1));
					it.target_col = 7'($urandom_range(SCREEN_COLS - 1));
				end
			end else if (pick < 88) begin
				it.operation = OP_READ;
				if ($urandom_range(7) != 0) begin
					it.target_row = 5'($urandom_range(SCREEN_ROWS - 1));
					it.target_col = 7'($urandom_range(SCREEN_COLS - 1));
				end
				// never read a cell the core holds no defined data for
				if (it.target_row < SCREEN_ROWS && it.target_col < SCREEN_COLS &&
						!known_q[it.target_row * SCREEN_COLS + it.target_col])
					it.target_row = 5'd31;
			end else if (pick < 91) begin
				it.operation = OP_CLEAR;
			end else begin
				it.operation = 3'($urandom_range(OP_UNUSED_LAST, OP_UNUSED_FIRST));
			end
			issue_command(it);
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n            = 1'b0;
		in_valid          = 1'b0;
		operation         = '0;
		char_code         = '0;
		attribute         = '0;
		use_default_color = 1'b0;
		target_row        = '0;
		target_col        = '0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		steady            = 1'b0;
		cursor_q          = 0;
		color_q           = TEXT_COLOR_RESET;
		blank_q           = BLANK_CELL_RESET;
		for (int i = 0; i < SCREEN_CELLS; i++) begin
			screen_q[i] = '0;
			known_q[i]  = 1'b0;
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_color_and_blank_extremes();
		test_newline_and_scroll();
		test_random_traffic(8'h00, 16'hFFFF, 130, 1'b0);
		test_random_traffic(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
			120, 1'b1);
		test_random_traffic(8'hFF, 16'h0000, 130, 1'b0);
		test_random_traffic(8'($urandom_range(255)), 16'($urandom_range(16'hFFFF)),
			120, 1'b0);

		settle_idle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
